// ----- src/hof_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hof_pkg
// shared widths, constants, command/status types and key helpers for the
// outlier filter
// ----------------------------------------------------------------------------
package hof_pkg;

   localparam int SAMPLE_W       = 17;
   localparam int THR_W          = 12;
   localparam int KEY_W          = 18;
   localparam int SCALE_W        = 17;
   localparam int PROD1_W        = THR_W + SCALE_W;
   localparam int PROD2_W        = PROD1_W + KEY_W;
   localparam int LHS_SHIFT      = 24;
   localparam int WINDOW_DEFAULT = 7;

   localparam logic [THR_W-1:0]   THR_RESET = 12'd512;
   localparam logic [SCALE_W-1:0] SCALE_Q16 = 17'd97164;

   typedef struct packed {
      logic shift;
      logic load_samples;
      logic load_devs;
      logic search;
      logic take_med;
      logic take_mad;
      logic mul_scale;
      logic mul_mad;
      logic emit;
   } hof_cmd_type;

   typedef struct packed {
      logic hit;
   } hof_status_type;

   // order-preserving map of a signed sample onto an unsigned key
   function automatic logic [KEY_W-1:0] sample_to_key(input logic [SAMPLE_W-1:0] s);
      return {1'b0, ~s[SAMPLE_W-1], s[SAMPLE_W-2:0]};
   endfunction

   function automatic logic [SAMPLE_W-1:0] key_to_sample(input logic [KEY_W-1:0] k);
      return {~k[SAMPLE_W-1], k[SAMPLE_W-2:0]};
   endfunction

endpackage

// ----- src/hof_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hof_req_if
// sample channel: valid/ready handshake with one signed sample
// ----------------------------------------------------------------------------
interface hof_req_if;
   logic                         valid;
   logic                         ready;
   logic [hof_pkg::SAMPLE_W-1:0] sample_in;

   modport source  (output valid, output sample_in, input ready);
   modport sink    (input valid, input sample_in, output ready);
   modport monitor (input valid, input sample_in, input ready);
endinterface

// ----- src/hof_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hof_rsp_if
// result channel: valid/ready handshake with filtered sample and flag
// ----------------------------------------------------------------------------
interface hof_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hof_pkg::SAMPLE_W-1:0] sample_out;
   logic                         outlier;

   modport source  (output valid, output sample_out, output outlier, input ready);
   modport sink    (input valid, input sample_out, input outlier, output ready);
   modport monitor (input valid, input sample_out, input outlier, input ready);
endinterface

// ----- src/hampel_outlier_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hampel_outlier_filter
// windowed median / median-absolute-deviation outlier filter
// ----------------------------------------------------------------------------
//   channel  direction  payload                       handshake
//   req_if   in         sample_in[16:0] signed        valid/ready
//   rsp_if   out        sample_out[16:0] signed,      valid/ready
//                       outlier
//   csr      in         csr_wr_data[11:0] threshold   csr_wr_en strobe
//
// one transfer in, one transfer out; an item steps through shift, sample load,
// median search, deviation load, deviation-median search, threshold * scale,
// * mad and emit; each search probes 1..WINDOW candidates in the rank-select
// unit, one candidate per cycle
// reset clears the window to zero and sets the threshold to 2.0 (Q4.8 512)
// a finished result sits in the output register; the next sample is taken
// meanwhile, and a stalled output only holds the sequencer at its last step
// ----------------------------------------------------------------------------
module hampel_outlier_filter #(
   parameter int WINDOW = hof_pkg::WINDOW_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   hof_req_if.sink                   req_if,
   hof_rsp_if.source                 rsp_if,
   input  logic                      csr_wr_en,
   input  logic [hof_pkg::THR_W-1:0] csr_wr_data
);

   hof_pkg::hof_cmd_type    cmd;
   hof_pkg::hof_status_type status;

   // sequencer: one state per step, search states repeat until a hit
   hof_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // window, rank-select, multiplier and output payload register
   hof_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .sample_in   (req_if.sample_in),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .sample_out  (rsp_if.sample_out),
      .outlier     (rsp_if.outlier)
   );

endmodule

// ----- src/hof_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hof_ctrl
// sequencer: window update, two rank searches, threshold multiply, result
// ----------------------------------------------------------------------------
module hof_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  hof_pkg::hof_status_type status,
   output hof_pkg::hof_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD1 = 3'd1;
   localparam logic [2:0] S_SRCH1 = 3'd2;
   localparam logic [2:0] S_LOAD2 = 3'd3;
   localparam logic [2:0] S_SRCH2 = 3'd4;
   localparam logic [2:0] S_MUL1  = 3'd5;
   localparam logic [2:0] S_MUL2  = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.shift = 1'b1;
               state_in  = S_LOAD1;
            end
         end
         S_LOAD1: begin
            cmd.load_samples = 1'b1;
            state_in         = S_SRCH1;
         end
         S_SRCH1: begin
            if (status.hit) begin
               cmd.take_med = 1'b1;
               state_in     = S_LOAD2;
            end else begin
               cmd.search = 1'b1;
            end
         end
         S_LOAD2: begin
            cmd.load_devs = 1'b1;
            state_in      = S_SRCH2;
         end
         S_SRCH2: begin
            if (status.hit) begin
               cmd.take_mad = 1'b1;
               state_in     = S_MUL1;
            end else begin
               cmd.search = 1'b1;
            end
         end
         S_MUL1: begin
            cmd.mul_scale = 1'b1;
            state_in      = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_mad = 1'b1;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/hof_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hof_datapath
// sample window, shared rank-select unit, threshold multiplier and result
// register
// ----------------------------------------------------------------------------
module hof_datapath #(
   parameter int WINDOW = hof_pkg::WINDOW_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hof_pkg::hof_cmd_type         cmd,
   output hof_pkg::hof_status_type      status,
   input  logic [hof_pkg::SAMPLE_W-1:0] sample_in,
   input  logic                         csr_wr_en,
   input  logic [hof_pkg::THR_W-1:0]    csr_wr_data,
   output logic [hof_pkg::SAMPLE_W-1:0] sample_out,
   output logic                         outlier
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int HALF  = WINDOW / 2;
   localparam int SW    = hof_pkg::SAMPLE_W;
   localparam int KW    = hof_pkg::KEY_W;

   logic [SW-1:0]               window_ff [WINDOW];
   logic [KW-1:0]               keys_ff   [WINDOW];
   logic [IDX_W-1:0]            idx_ff;
   logic [SW-1:0]               med_ff;
   logic [KW-1:0]               mad_ff;
   logic [hof_pkg::THR_W-1:0]   thr_ff;
   logic [hof_pkg::PROD1_W-1:0] p1_ff;
   logic [hof_pkg::PROD2_W-1:0] p2_ff;
   logic [SW-1:0]               sample_out_ff;
   logic                        outlier_ff;

   logic [KW-1:0]               cand;
   logic [CNT_W-1:0]            lt_cnt, le_cnt;
   logic [KW-1:0]               dev_key [WINDOW];
   logic [hof_pkg::PROD2_W-1:0] lhs;
   logic                        pass;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= hof_pkg::THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // sample window, oldest at index 0
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            window_ff[i] <= '0;
         end
      end else if (cmd.shift) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            window_ff[i] <= window_ff[i+1];
         end
         window_ff[WINDOW-1] <= sample_in;
      end
   end

   // absolute deviation of every tap from the median
   always_comb begin
      logic signed [KW-1:0] diff;
      for (int i = 0; i < WINDOW; i++) begin
         diff = $signed({window_ff[i][SW-1], window_ff[i]})
              - $signed({med_ff[SW-1], med_ff});
         dev_key[i] = diff[KW-1] ? KW'(-diff) : KW'(diff);
      end
   end

   // rank test of one candidate against all keys
   assign cand = keys_ff[idx_ff];

   always_comb begin
      lt_cnt = '0;
      le_cnt = '0;
      for (int i = 0; i < WINDOW; i++) begin
         lt_cnt = lt_cnt + CNT_W'(keys_ff[i] <  cand);
         le_cnt = le_cnt + CNT_W'(keys_ff[i] <= cand);
      end
   end

   assign status.hit = (lt_cnt <= CNT_W'(HALF)) && (le_cnt > CNT_W'(HALF));

   always_ff @(posedge clock) begin
      if (cmd.load_samples) begin
         for (int i = 0; i < WINDOW; i++) begin
            keys_ff[i] <= hof_pkg::sample_to_key(window_ff[i]);
         end
      end else if (cmd.load_devs) begin
         for (int i = 0; i < WINDOW; i++) begin
            keys_ff[i] <= dev_key[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_samples || cmd.load_devs) begin
         idx_ff <= '0;
      end else if (cmd.search) begin
         idx_ff <= (idx_ff == IDX_W'(WINDOW - 1)) ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_med) begin
         med_ff <= hof_pkg::key_to_sample(cand);
      end
      if (cmd.take_mad) begin
         mad_ff <= cand;
      end
   end

   // threshold * scale, then * mad
   always_ff @(posedge clock) begin
      if (cmd.mul_scale) begin
         p1_ff <= hof_pkg::PROD1_W'(thr_ff) * hof_pkg::PROD1_W'(hof_pkg::SCALE_Q16);
      end
      if (cmd.mul_mad) begin
         p2_ff <= hof_pkg::PROD2_W'(p1_ff) * hof_pkg::PROD2_W'(mad_ff);
      end
   end

   // keys still hold the deviations; the center one sits at index HALF
   assign lhs  = hof_pkg::PROD2_W'({keys_ff[HALF], {hof_pkg::LHS_SHIFT{1'b0}}});
   assign pass = (lhs <= p2_ff);

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         sample_out_ff <= pass ? window_ff[HALF] : med_ff;
         outlier_ff    <= !pass;
      end
   end

   assign sample_out = sample_out_ff;
   assign outlier    = outlier_ff;

endmodule

// ----- src/hof_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hof_checker
// port-level checks on the outlier filter, bound to the top level
// ----------------------------------------------------------------------------
module hof_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [hof_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input logic                         rsp_outlier
);

   // a pending result waits for its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // a pending result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample_out) && $stable(rsp_outlier))
      else $error("result payload changed before transfer");

   // one sample in flight: no second transfer right after one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample taken while another is in progress");

   // no result appears in the cycle after a sample transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

   // nothing pending right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind hampel_outlier_filter hof_checker u_hof_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_sample_out (rsp_if.sample_out),
   .rsp_outlier    (rsp_if.outlier)
);

// ----- tb/tb_hampel_outlier_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hampel_outlier_filter
// self-checking bench for the windowed median / MAD outlier filter
// ----------------------------------------------------------------------------
// queue-fed driver, local copy of the sample window shifted on each transfer
// median, deviation median and exact integer threshold compare worked out here
// predicted sample and flag queued, checked in order on every result transfer
// threshold register rewritten between phases while the filter is drained
// random idling on both handshakes
// one phase holds the result side off long enough to back up the input
// ----------------------------------------------------------------------------
module tb_hampel_outlier_filter;

   localparam int WINDOW          = hof_pkg::WINDOW_DEFAULT;
   localparam int SAMPLE_W        = hof_pkg::SAMPLE_W;
   localparam int THR_W           = hof_pkg::THR_W;
   localparam int SAMPLE_MIN      = -65536;
   localparam int SAMPLE_MAX      = 65535;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 24;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                outlier;
   } filtered_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [THR_W-1:0]  csr_wr_data;

   hof_req_if req_bus ();
   hof_rsp_if rsp_bus ();

   // samples waiting for the driver, filtered results waiting for the filter
   logic [SAMPLE_W-1:0] samples_to_send [$];
   filtered_type        filtered_due [$];

   // local copy of the filter state
   int               window_model [WINDOW];
   logic [THR_W-1:0] threshold_model;

   int sender_idle_pct;
   int receiver_idle_pct;
   logic hold_go;
   int   hold_left;

   int cycle_count;
   int error_count;
   int samples_taken;
   int results_checked;
   int outliers_seen;
   int input_stall_cycles;
   int thresholds_used;

   // edge values, spikes on a zero window (zero deviation), a centered zero
   // that matches the median, small values around zero and a cluster around 100
   int directed_vals [24] = '{65535, -65536, 0, 0, 0, 65535, 0, 0, 0, -65536, 0, 0,
                              0, 1, -1, 2, -2, 65535, -65536, 65535, -65536, 100,
                              101, 99};

   hampel_outlier_filter #(
      .WINDOW (WINDOW)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // element of rank WINDOW/2 in ascending order
   function automatic int middle_rank(input int vals [WINDOW]);
      int sorted [WINDOW];
      int key;
      int j;
      sorted = vals;
      for (int i = 1; i < WINDOW; i++) begin
         key = sorted[i];
         j   = i - 1;
         while (j >= 0 && sorted[j] > key) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = key;
      end
      return sorted[WINDOW / 2];
   endfunction

   // median, deviation median and the exact compare
   //   |center - median| * 2^24 <= threshold * scale * mad
   function automatic filtered_type predict_filtered(input int line [WINDOW],
                                                     input logic [THR_W-1:0] thr);
      int devs [WINDOW];
      int med;
      int mad;
      int center;
      int gap;
      longint unsigned lhs;
      longint unsigned rhs;
      filtered_type res;
      med = middle_rank(line);
      for (int i = 0; i < WINDOW; i++)
         devs[i] = (line[i] >= med) ? line[i] - med : med - line[i];
      mad    = middle_rank(devs);
      center = line[WINDOW / 2];
      gap    = (center >= med) ? center - med : med - center;
      lhs    = longint'(gap) << hof_pkg::LHS_SHIFT;
      rhs    = longint'(thr) * longint'(hof_pkg::SCALE_Q16) * longint'(mad);
      if (lhs > rhs) begin
         res.sample  = med[SAMPLE_W-1:0];
         res.outlier = 1'b1;
      end else begin
         res.sample  = center[SAMPLE_W-1:0];
         res.outlier = 1'b0;
      end
      return res;
   endfunction

   // driver: offers queued samples, predicts on every accepted transfer
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.sample_in <= '0;
         for (int i = 0; i < WINDOW; i++)
            window_model[i] = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            for (int i = 0; i < WINDOW - 1; i++)
               window_model[i] = window_model[i + 1];
            window_model[WINDOW - 1] = $signed(req_bus.sample_in);
            filtered_due.push_back(predict_filtered(window_model, threshold_model));
            samples_taken++;
         end
         if (req_bus.valid && !req_bus.ready)
            input_stall_cycles++;
         if (!req_bus.valid || req_bus.ready) begin
            if (samples_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_bus.valid     <= 1'b1;
               req_bus.sample_in <= samples_to_send.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // threshold copy follows the register write
   always @(posedge clock) begin
      if (reset)
         threshold_model <= hof_pkg::THR_RESET;
      else if (csr_wr_en)
         threshold_model <= csr_wr_data;
   end

   // long hold-off of the result side, counted here
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_go)
         hold_left <= HOLD_OFF_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // receiver ready: random idling, forced low during the hold-off
   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
   end

   // monitor: every result transfer against the oldest prediction
   always @(posedge clock) begin
      filtered_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_checked++;
         if (rsp_bus.outlier)
            outliers_seen++;
         if (filtered_due.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: result with nothing expected: sample %0d outlier %0b",
                        $realtime, $signed(rsp_bus.sample_out), rsp_bus.outlier);
         end else begin
            want = filtered_due.pop_front();
            if (rsp_bus.sample_out !== want.sample || rsp_bus.outlier !== want.outlier) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: mismatch: sample exp %0d got %0d, outlier exp %0b got %0b",
                           $realtime, $signed(want.sample), $signed(rsp_bus.sample_out),
                           want.outlier, rsp_bus.outlier);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, filtered_due.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // wait until nothing is queued, offered or outstanding, plus some slack
   task automatic wait_for_drain();
      do @(negedge clock);
      while (samples_to_send.size() != 0 || req_bus.valid || filtered_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] thr);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= thr;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      thresholds_used++;
   endtask

   // sensor-like stream: a level with noise of random spread, plateaus of
   // equal values, spikes, rail values and some uniform noise
   task automatic queue_stream(input int count);
      int level;
      int spread;
      int value;
      int pick;
      level  = int'($urandom_range(0, 131071)) + SAMPLE_MIN;
      spread = 8;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(39) == 0) begin
            level  = int'($urandom_range(0, 131071)) + SAMPLE_MIN;
            spread = 1 << $urandom_range(0, 12);
         end
         pick = $urandom_range(99);
         if (pick < 65)
            value = level + int'($urandom_range(0, 2 * spread)) - spread;
         else if (pick < 72)
            value = level;
         else if (pick < 84)
            value = level + ($urandom_range(1) ? 1 : -1) *
                    int'($urandom_range(4 * spread, SAMPLE_MAX));
         else if (pick < 92)
            value = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
         else
            value = int'($urandom_range(0, 131071)) + SAMPLE_MIN;
         if (value > SAMPLE_MAX)
            value = SAMPLE_MAX;
         if (value < SAMPLE_MIN)
            value = SAMPLE_MIN;
         samples_to_send.push_back(value[SAMPLE_W-1:0]);
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.sample_in  = '0;
      rsp_bus.ready      = 1'b0;
      hold_go            = 1'b0;
      cycle_count        = 0;
      error_count        = 0;
      samples_taken      = 0;
      results_checked    = 0;
      outliers_seen      = 0;
      input_stall_cycles = 0;
      thresholds_used    = 0;
      // sender rarely idles, receiver mostly does
      sender_idle_pct    = 7;
      receiver_idle_pct  = 83;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part on the reset threshold of 2.0
      foreach (directed_vals[i]) begin
         int dv;
         dv = directed_vals[i];
         samples_to_send.push_back(dv[SAMPLE_W-1:0]);
      end
      wait_for_drain();

      // zero threshold: anything off the median is flagged
      write_threshold('0);
      queue_stream(120);
      wait_for_drain();

      // widest threshold
      write_threshold({THR_W{1'b1}});
      queue_stream(120);
      wait_for_drain();

      // roles swapped: sender mostly idle, receiver rarely
      sender_idle_pct   = 83;
      receiver_idle_pct = 7;
      write_threshold(THR_W'(256));
      queue_stream(120);
      wait_for_drain();

      write_threshold(THR_W'($urandom_range(1, 1023)));
      queue_stream(100);
      wait_for_drain();

      // no idling; long receiver hold-off while the sender keeps offering
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_threshold(THR_W'($urandom_range(0, 4095)));
      @(posedge clock);
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      queue_stream(150);
      wait_for_drain();

      write_threshold(THR_W'($urandom_range(300, 800)));
      queue_stream(100);
      wait_for_drain();

      $display("covered %0d samples and %0d results (%0d outliers) over %0d thresholds",
               samples_taken, results_checked, outliers_seen, thresholds_used);
      $display("input held back for %0d cycles, %0d errors", input_stall_cycles,
               error_count);
      if (error_count == 0 && filtered_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
